// ----- rtl/core/imupr_pkg.sv -----
// ----------------------------------------------------------------------------
// imupr_pkg
// Shared constants and types of the sensor-hub packet record parser.
// ----------------------------------------------------------------------------
package imupr_pkg;

   // Default packet byte position limit; payload bytes at or beyond it are not parsed
   localparam int PACKET_LIMIT_DEFAULT = 280;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 15;
   localparam int OFFSET_W = 4;
   localparam int VEC_W    = 16;

   // Header layout
   localparam logic [POS_W-1:0]  HDR_LEN_LO   = 15'd0;
   localparam logic [POS_W-1:0]  HDR_LEN_HI   = 15'd1;
   localparam logic [POS_W-1:0]  HDR_CHANNEL  = 15'd2;
   localparam logic [POS_W-1:0]  HDR_SEQUENCE = 15'd3;
   localparam logic [POS_W-1:0]  PAYLOAD_START = 15'd4;
   localparam logic [POS_W-1:0]  MIN_PACKET_LEN = 15'd5;
   localparam logic [BYTE_W-1:0] LEN_HI_MASK  = 8'h7F;

   // Record ids
   localparam logic [BYTE_W-1:0] ID_TIME_BASE  = 8'hFB;
   localparam logic [BYTE_W-1:0] ID_TIME_DELTA = 8'hFA;
   localparam logic [BYTE_W-1:0] ID_ROTATION   = 8'h05;
   localparam logic [BYTE_W-1:0] ID_GAME_ROT   = 8'h08;
   localparam logic [BYTE_W-1:0] ID_LIN_ACCEL  = 8'h04;

   // Record lengths and data window
   localparam logic [OFFSET_W-1:0] TIME_REC_LEN   = 4'd5;
   localparam logic [OFFSET_W-1:0] ROT_REC_LEN    = 4'd12;
   localparam logic [OFFSET_W-1:0] ACCEL_REC_LEN  = 4'd10;
   localparam logic [OFFSET_W-1:0] DATA_FIRST     = 4'd4;
   localparam logic [OFFSET_W-1:0] DATA_END       = 4'd12;

   // Result kinds
   localparam logic KIND_ROTATION = 1'b0;
   localparam logic KIND_ACCEL    = 1'b1;

   // Reset value of the report channel register
   localparam logic [BYTE_W-1:0] REPORT_CHANNEL_RESET = 8'd3;

   // One result word
   typedef struct packed {
      logic                    record_kind;
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic signed [VEC_W-1:0] vec_z;
      logic signed [VEC_W-1:0] vec_w;
   } rsp_word_type;

   // Result of one parser step
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } step_result_type;

endpackage

// ----- rtl/core/imupr_if.sv -----
// ----------------------------------------------------------------------------
// imupr_if
// Valid/ready channels of the packet record parser: byte input and results.
// ----------------------------------------------------------------------------
interface imupr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface imupr_rsp_if;
   logic               valid;
   logic               ready;
   logic               record_kind;
   logic signed [15:0] vec_x;
   logic signed [15:0] vec_y;
   logic signed [15:0] vec_z;
   logic signed [15:0] vec_w;

   modport source (output valid, output record_kind, output vec_x, output vec_y,
                   output vec_z, output vec_w, input ready);
   modport sink   (input valid, input record_kind, input vec_x, input vec_y,
                   input vec_z, input vec_w, output ready);
endinterface

// ----- rtl/core/imu_packet_record_parser.sv -----
// ----------------------------------------------------------------------------
// imu_packet_record_parser
// Sensor-hub packet stream parser that emits rotation and acceleration records.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle and keeps that rate as long
// as results are taken. Each byte passes an input register, then updates the
// header and record state; a completed rotation or linear acceleration record
// is then loaded into the result register. The result register is the only
// buffer: while a result waits, the byte behind it holds in the input
// register and further bytes stall. report_channel (csr_write_data, reset 3)
// selects the channel whose payload is walked; the user must write it only
// while the block is idle, which the block itself does not enforce.
module imu_packet_record_parser
   import imupr_pkg::*;
#(
   parameter int PACKET_LIMIT = PACKET_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   imupr_req_if.sink         req,
   imupr_rsp_if.source       rsp,
   input  logic              csr_write_enable,
   input  logic [BYTE_W-1:0] csr_write_data
);

   logic [BYTE_W-1:0] report_channel_ff;
   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              out_valid_ff;
   rsp_word_type      out_word_ff;
   logic              advance;
   step_result_type   step_result;

   // Hold the report channel register
   always_ff @(posedge clock) begin
      if (reset) begin
         report_channel_ff <= REPORT_CHANNEL_RESET;
      end else if (csr_write_enable) begin
         report_channel_ff <= csr_write_data;
      end
   end

   // Step the parser when a byte is staged and the result slot is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff <= req.data_byte;
      end
   end

   imupr_core #(
      .PACKET_LIMIT (PACKET_LIMIT)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .data_byte      (in_byte_ff),
      .report_channel (report_channel_ff),
      .result         (step_result)
   );

   // Result register: drop a taken word, load a new one
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= step_result.valid;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_result.valid) begin
         out_word_ff <= step_result.word;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.record_kind = out_word_ff.record_kind;
   assign rsp.vec_x       = out_word_ff.vec_x;
   assign rsp.vec_y       = out_word_ff.vec_y;
   assign rsp.vec_z       = out_word_ff.vec_z;
   assign rsp.vec_w       = out_word_ff.vec_w;

endmodule

// ----- rtl/core/imupr_core.sv -----
// ----------------------------------------------------------------------------
// imupr_core
// Packet and record state of the parser; one byte is consumed per step and
// the result of a completed record is presented in the same cycle.
// ----------------------------------------------------------------------------
module imupr_core
   import imupr_pkg::*;
#(
   parameter int PACKET_LIMIT = PACKET_LIMIT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic [BYTE_W-1:0] report_channel,
   output step_result_type   result
);

   localparam logic [POS_W-1:0] LIMIT_POS = POS_W'(PACKET_LIMIT);

   logic [POS_W-1:0]    byte_position_ff, byte_position_in;
   logic [POS_W-1:0]    packet_length_ff, packet_length_in;
   logic [BYTE_W-1:0]   packet_channel_ff, packet_channel_in;
   logic [BYTE_W-1:0]   record_id_ff, record_id_in;
   logic [OFFSET_W-1:0] record_offset_ff, record_offset_in;
   logic [63:0]         record_bytes_ff, record_bytes_in;
   logic                ignore_rest_ff, ignore_rest_in;

   logic [POS_W-1:0]    pos_inc;
   logic [OFFSET_W-1:0] offset_inc;
   logic [2:0]          lane_offset;
   logic [63:0]         bytes_merged;
   logic                id_known;
   logic                parse_byte;

   assign pos_inc     = byte_position_ff + 1'b1;
   assign offset_inc  = record_offset_ff + 1'b1;
   assign lane_offset = 3'(record_offset_ff - DATA_FIRST);
   assign parse_byte  = (byte_position_ff < LIMIT_POS) && !ignore_rest_ff &&
                        (packet_channel_ff == report_channel);

   // Classify the id byte that opens a record
   always_comb begin
      case (data_byte) inside
         ID_TIME_BASE, ID_TIME_DELTA, ID_ROTATION, ID_GAME_ROT, ID_LIN_ACCEL: begin
            id_known = 1'b1;
         end
         default: begin
            id_known = 1'b0;
         end
      endcase
   end

   // Place a data byte into its lane of the record buffer
   always_comb begin
      bytes_merged = record_bytes_ff;
      if (record_offset_ff >= DATA_FIRST && record_offset_ff < DATA_END) begin
         bytes_merged[lane_offset*8 +: 8] = data_byte;
      end
   end

   // Advance header and record state by one byte
   always_comb begin
      byte_position_in  = byte_position_ff;
      packet_length_in  = packet_length_ff;
      packet_channel_in = packet_channel_ff;
      record_id_in      = record_id_ff;
      record_offset_in  = record_offset_ff;
      record_bytes_in   = record_bytes_ff;
      ignore_rest_in    = ignore_rest_ff;
      result            = '0;

      if (byte_position_ff == HDR_LEN_LO) begin
         packet_length_in = {{(POS_W-BYTE_W){1'b0}}, data_byte};
         record_id_in     = '0;
         record_offset_in = '0;
         record_bytes_in  = '0;
         ignore_rest_in   = 1'b0;
         byte_position_in = HDR_LEN_HI;
      end else if (byte_position_ff == HDR_LEN_HI) begin
         packet_length_in = {data_byte[6:0] & LEN_HI_MASK[6:0], packet_length_ff[7:0]};
         byte_position_in = HDR_CHANNEL;
      end else if (byte_position_ff == HDR_CHANNEL) begin
         packet_channel_in = data_byte;
         byte_position_in  = HDR_SEQUENCE;
      end else if (byte_position_ff == HDR_SEQUENCE) begin
         byte_position_in = (packet_length_ff < MIN_PACKET_LEN) ? HDR_LEN_LO
                                                                : PAYLOAD_START;
      end else begin
         // Walk the payload as records
         if (parse_byte) begin
            if (record_offset_ff == '0) begin
               record_id_in    = data_byte;
               record_bytes_in = '0;
               if (id_known) begin
                  record_offset_in = 4'd1;
               end else begin
                  ignore_rest_in = 1'b1;
               end
            end else if (record_id_ff == ID_TIME_BASE || record_id_ff == ID_TIME_DELTA) begin
               record_offset_in = (offset_inc >= TIME_REC_LEN) ? '0 : offset_inc;
            end else begin
               record_bytes_in  = bytes_merged;
               record_offset_in = offset_inc;
               if ((record_id_ff == ID_ROTATION || record_id_ff == ID_GAME_ROT) &&
                   offset_inc >= ROT_REC_LEN) begin
                  record_offset_in        = '0;
                  result.valid            = 1'b1;
                  result.word.record_kind = KIND_ROTATION;
                  result.word.vec_x       = bytes_merged[15:0];
                  result.word.vec_y       = bytes_merged[31:16];
                  result.word.vec_z       = bytes_merged[47:32];
                  result.word.vec_w       = bytes_merged[63:48];
               end else if (record_id_ff == ID_LIN_ACCEL && offset_inc >= ACCEL_REC_LEN) begin
                  record_offset_in        = '0;
                  result.valid            = 1'b1;
                  result.word.record_kind = KIND_ACCEL;
                  result.word.vec_x       = bytes_merged[15:0];
                  result.word.vec_y       = bytes_merged[31:16];
                  result.word.vec_z       = bytes_merged[47:32];
                  result.word.vec_w       = '0;
               end
            end
         end
         // Close the packet after its length
         byte_position_in = (pos_inc >= packet_length_ff) ? HDR_LEN_LO : pos_inc;
      end

      if (!step_en) begin
         result.valid = 1'b0;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         packet_length_ff  <= '0;
         packet_channel_ff <= '0;
         record_id_ff      <= '0;
         record_offset_ff  <= '0;
         record_bytes_ff   <= '0;
         ignore_rest_ff    <= 1'b0;
      end else if (step_en) begin
         byte_position_ff  <= byte_position_in;
         packet_length_ff  <= packet_length_in;
         packet_channel_ff <= packet_channel_in;
         record_id_ff      <= record_id_in;
         record_offset_ff  <= record_offset_in;
         record_bytes_ff   <= record_bytes_in;
         ignore_rest_ff    <= ignore_rest_in;
      end
   end

endmodule
